// File: sv/pixel_point_operation_unit_top_defines.svh
// Assertion macros shared by the pixel point operation unit RTL.
`ifndef PIXEL_POINT_OPERATION_UNIT_TOP_DEFINES_SVH
`define PIXEL_POINT_OPERATION_UNIT_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPOU_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PPOU_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/ppou_pkg.sv
// Types and constants shared by the pixel point operation unit.
package ppou_pkg;

    // Operation codes of the mode register; codes 6 and 7 pass the pixel through.
    typedef enum logic [2:0] {
        MODE_AVG_GRAY  = 3'd0,
        MODE_LUM_GRAY  = 3'd1,
        MODE_MASK      = 3'd2,
        MODE_INVERT    = 3'd3,
        MODE_BRIGHTEN  = 3'd4,
        MODE_CONTRAST  = 3'd5
    } t_mode;

    // Register indexes (byte address = 4 * index); index 7 is unmapped.
    typedef enum logic [2:0] {
        REG_MODE            = 3'd0,
        REG_CHANNELS        = 3'd1,
        REG_MASK_RED        = 3'd2,
        REG_MASK_GREEN      = 3'd3,
        REG_MASK_BLUE       = 3'd4,
        REG_BRIGHT_OFFSET   = 3'd5,
        REG_CONTRAST_ADJUST = 3'd6
    } t_reg_idx;

    // Status of the contrast gain divider.
    typedef struct packed {
        logic busy;
        logic done;
    } t_gain_status;

    localparam logic [2:0]  MODE_RESET     = 3'd4;
    localparam logic [2:0]  CHANNELS_RESET = 3'd3;
    localparam logic [2:0]  COLOR_MIN_CHAN = 3'd3;
    localparam logic [8:0]  MASK_UNITY     = 9'd256;

    // Q8.8 contrast gain: unity at reset, largest reachable value at adjust = 255.
    localparam logic [15:0] GAIN_RESET     = 16'd256;
    localparam logic [15:0] GAIN_MAX       = 16'd33152;

    // Luminance weights in Q16.
    localparam logic [15:0] LUM_W0 = 16'd13933;
    localparam logic [15:0] LUM_W1 = 16'd46871;
    localparam logic [15:0] LUM_W2 = 16'd4732;

    // floor(s/3) == (s * 683) >> 11 for s <= 765.
    localparam logic [9:0]  AVG_RECIP  = 10'd683;
    localparam int          AVG_SHIFT  = 11;

    // Gain divider: 26-bit dividend, 17-bit divisor, one quotient bit per cycle.
    localparam int NUM_W      = 26;
    localparam int DEN_W      = 17;
    localparam int DIV_STEPS  = NUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

endpackage

// File: sv/ppou_gain_div.sv
// Contrast gain unit: restoring divider for floor(259*(a+255)*256 / (255*(259-a))).
module ppou_gain_div (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic signed [8:0]      i_adjust,
    output ppou_pkg::t_gain_status o_status,
    output logic [15:0]            o_gain
);

    logic [9:0]                       w_ext;
    logic [8:0]                       w_x;
    logic [9:0]                       w_y;
    logic [17:0]                      w_num18;
    logic [ppou_pkg::NUM_W-1:0]       w_num;
    logic [ppou_pkg::DEN_W-1:0]       w_den;
    logic [ppou_pkg::DEN_W:0]         w_trial;
    logic                             w_ge;
    logic [ppou_pkg::DEN_W-1:0]       w_rem_n;
    logic [ppou_pkg::NUM_W-1:0]       w_quo_n;
    logic                             w_last;

    logic                             r_busy;
    logic                             r_done;
    logic [ppou_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [ppou_pkg::DEN_W-1:0]       r_rem;
    logic [ppou_pkg::NUM_W-1:0]       r_quo;
    logic [ppou_pkg::DEN_W-1:0]       r_den;
    logic [15:0]                      r_gain;

    // Operands: x = max(a+255, 0), y = 259 - a.
    always_comb begin
        w_ext   = {i_adjust[8], i_adjust} + 10'd255;
        w_x     = (i_adjust == 9'h100) ? 9'd0 : w_ext[8:0];
        w_y     = 10'd259 - {i_adjust[8], i_adjust};
        w_num18 = 18'({w_x, 8'b0}) + 18'({w_x, 1'b0}) + 18'(w_x);
        w_num   = {w_num18, 8'b0};
        w_den   = 17'({w_y, 8'b0}) - 17'(w_y);
    end

    always_comb begin
        w_trial = {r_rem, r_quo[ppou_pkg::NUM_W-1]};
        w_ge    = (w_trial >= {1'b0, r_den});
        w_rem_n = w_ge ? ppou_pkg::DEN_W'(w_trial - {1'b0, r_den})
                       : w_trial[ppou_pkg::DEN_W-1:0];
        w_quo_n = {r_quo[ppou_pkg::NUM_W-2:0], w_ge};
        w_last  = r_busy && (r_cnt == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_gain <= ppou_pkg::GAIN_RESET;
        end else begin
            r_done <= w_last;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (w_last) begin
                r_busy <= 1'b0;
                r_gain <= (|w_quo_n[ppou_pkg::NUM_W-1:16]) ? 16'hFFFF : w_quo_n[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= w_num;
            r_rem <= '0;
            r_den <= w_den;
            r_cnt <= ppou_pkg::DIV_CNT_W'(ppou_pkg::DIV_STEPS - 1);
        end else if (r_busy) begin
            r_quo <= w_quo_n;
            r_rem <= w_rem_n;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_gain        = r_gain;

endmodule

// File: sv/pixel_point_operation_unit_top.sv
// Pixel point operation unit: gray, mask, invert, brighten and contrast on one pixel per word.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+-------------------------------
//  pixel in  | i_in_valid / o_in_stall    | i_chan0..i_chan3, 8 bits each
//  pixel out | o_out_valid / i_out_stall  | o_out0..o_out3, 8 bits each
//  config    | psel/penable/pwrite/pready | paddr[4:0], pwdata, prdata
//
// One word per cycle sustained while the output is not stalled and no gain division
// runs; each word passes products, post-processing and output select/register.
// Writing contrast_adjust starts a gain division, one quotient bit per cycle;
// o_in_stall is held high until it finishes.
// Reset (i_rst_n low, synchronous) empties the pipe and loads register defaults.
// A stall on the output only holds stages that are full; bubbles ahead still close.
`include "pixel_point_operation_unit_top_defines.svh"

module pixel_point_operation_unit_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // pixel in
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_chan0,
    input  logic [7:0]  i_chan1,
    input  logic [7:0]  i_chan2,
    input  logic [7:0]  i_chan3,
    // pixel out
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out0,
    output logic [7:0]  o_out1,
    output logic [7:0]  o_out2,
    output logic [7:0]  o_out3,
    // config
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [2:0]  r_mode;
    logic [2:0]  r_chans;
    logic [8:0]  r_mask_r;
    logic [8:0]  r_mask_g;
    logic [8:0]  r_mask_b;
    logic [8:0]  r_bright;
    logic [8:0]  r_adjust;

    logic        w_cfg_wr;
    logic [2:0]  w_idx;
    logic        w_gain_start;

    ppou_pkg::t_gain_status w_gain_st;
    logic [15:0]            w_gain;

    assign pready       = 1'b1;
    assign w_cfg_wr     = psel && penable && pwrite;
    assign w_idx        = paddr[4:2];
    assign w_gain_start = w_cfg_wr && (w_idx == ppou_pkg::REG_CONTRAST_ADJUST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= ppou_pkg::MODE_RESET;
            r_chans  <= ppou_pkg::CHANNELS_RESET;
            r_mask_r <= ppou_pkg::MASK_UNITY;
            r_mask_g <= ppou_pkg::MASK_UNITY;
            r_mask_b <= ppou_pkg::MASK_UNITY;
            r_bright <= '0;
            r_adjust <= '0;
        end else if (w_cfg_wr) begin
            case (w_idx)
                ppou_pkg::REG_MODE:            r_mode   <= pwdata[2:0];
                ppou_pkg::REG_CHANNELS:        r_chans  <= pwdata[2:0];
                ppou_pkg::REG_MASK_RED:        r_mask_r <= pwdata[8:0];
                ppou_pkg::REG_MASK_GREEN:      r_mask_g <= pwdata[8:0];
                ppou_pkg::REG_MASK_BLUE:       r_mask_b <= pwdata[8:0];
                ppou_pkg::REG_BRIGHT_OFFSET:   r_bright <= pwdata[8:0];
                ppou_pkg::REG_CONTRAST_ADJUST: r_adjust <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            ppou_pkg::REG_MODE:            prdata = 32'(r_mode);
            ppou_pkg::REG_CHANNELS:        prdata = 32'(r_chans);
            ppou_pkg::REG_MASK_RED:        prdata = 32'(r_mask_r);
            ppou_pkg::REG_MASK_GREEN:      prdata = 32'(r_mask_g);
            ppou_pkg::REG_MASK_BLUE:       prdata = 32'(r_mask_b);
            ppou_pkg::REG_BRIGHT_OFFSET:   prdata = 32'(r_bright);
            ppou_pkg::REG_CONTRAST_ADJUST: prdata = 32'(r_adjust);
            default:                       prdata = '0;
        endcase
    end

    // Q8.8 gain from contrast_adjust, recomputed on each write.
    ppou_gain_div u_gain_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_gain_start),
        .i_adjust ($signed(pwdata[8:0])),
        .o_status (w_gain_st),
        .o_gain   (w_gain)
    );

    // ---------------------------------------------------------------
    // Flow control: a stage loads when it is empty or its word moves on.
    // ---------------------------------------------------------------
    logic r1_v, r2_v, r3_v;
    logic w_rdy1, w_rdy2, w_rdy3;
    logic w_in_acc;

    assign w_rdy3     = !r3_v || !i_out_stall;
    assign w_rdy2     = !r2_v || w_rdy3;
    assign w_rdy1     = !r1_v || w_rdy2;
    assign o_in_stall = !w_rdy1 || w_gain_st.busy;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r1_v <= w_in_acc;
            end
            if (w_rdy2) begin
                r2_v <= r1_v;
            end
            if (w_rdy3) begin
                r3_v <= r2_v;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: products
    // ---------------------------------------------------------------
    logic [7:0]         w_c     [4];
    logic [15:0]        w_lum_w [3];
    logic [8:0]         w_mgain [3];
    logic [23:0]        w_lum   [3];
    logic [16:0]        w_mprod [3];
    logic signed [24:0] w_cprod [3];
    logic signed [7:0]  w_cd    [3];

    logic [7:0]         r1_c     [4];
    logic [23:0]        r1_lum   [3];
    logic [16:0]        r1_mprod [3];
    logic signed [24:0] r1_cprod [3];
    logic [9:0]         r1_sum;

    assign w_c[0] = i_chan0;
    assign w_c[1] = i_chan1;
    assign w_c[2] = i_chan2;
    assign w_c[3] = i_chan3;

    assign w_lum_w[0] = ppou_pkg::LUM_W0;
    assign w_lum_w[1] = ppou_pkg::LUM_W1;
    assign w_lum_w[2] = ppou_pkg::LUM_W2;

    assign w_mgain[0] = r_mask_r;
    assign w_mgain[1] = r_mask_g;
    assign w_mgain[2] = r_mask_b;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_lum[k]   = 24'(w_lum_w[k]) * 24'(w_c[k]);
            w_mprod[k] = 17'(w_c[k]) * 17'(w_mgain[k]);
            // c - 128 as 8-bit two's complement
            w_cd[k]    = $signed({~w_c[k][7], w_c[k][6:0]});
            w_cprod[k] = 25'($signed({1'b0, w_gain})) * 25'(w_cd[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            for (int k = 0; k < 4; k++) begin
                r1_c[k] <= w_c[k];
            end
            for (int k = 0; k < 3; k++) begin
                r1_lum[k]   <= w_lum[k];
                r1_mprod[k] <= w_mprod[k];
                r1_cprod[k] <= w_cprod[k];
            end
            r1_sum <= 10'(i_chan0) + 10'(i_chan1) + 10'(i_chan2);
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: shift, saturate and clamp; per-channel point op chosen
    // ---------------------------------------------------------------
    logic [23:0]        w_lum_sum;
    logic [19:0]        w_avg_prod;
    logic [7:0]         w_gray;
    logic [7:0]         w_mask   [3];
    logic [7:0]         w_pt     [3];
    logic signed [9:0]  w_bsum   [3];
    logic [7:0]         w_bright [3];
    logic signed [24:0] w_cx     [3];
    logic [7:0]         w_contr  [3];

    logic [7:0]         r2_c    [4];
    logic [7:0]         r2_gray;
    logic [7:0]         r2_mask [3];
    logic [7:0]         r2_pt   [3];

    always_comb begin
        w_lum_sum  = r1_lum[0] + r1_lum[1] + r1_lum[2];
        w_avg_prod = 20'(r1_sum) * 20'(ppou_pkg::AVG_RECIP);
        if (r_mode == ppou_pkg::MODE_LUM_GRAY) begin
            w_gray = w_lum_sum[23:16];
        end else begin
            w_gray = w_avg_prod[ppou_pkg::AVG_SHIFT +: 8];
        end

        for (int k = 0; k < 3; k++) begin
            w_mask[k] = r1_mprod[k][16] ? 8'hFF : r1_mprod[k][15:8];

            w_bsum[k] = $signed({2'b00, r1_c[k]}) + $signed({r_bright[8], r_bright});
            if (w_bsum[k][9]) begin
                w_bright[k] = 8'd0;
            end else if (w_bsum[k][8]) begin
                w_bright[k] = 8'hFF;
            end else begin
                w_bright[k] = w_bsum[k][7:0];
            end

            // gain*(c-128) + 128.0 in Q8.8; negative clamps to zero
            w_cx[k] = r1_cprod[k] + 25'sd32768;
            if (w_cx[k][24]) begin
                w_contr[k] = 8'd0;
            end else if (|w_cx[k][23:16]) begin
                w_contr[k] = 8'hFF;
            end else begin
                w_contr[k] = w_cx[k][15:8];
            end

            case (r_mode)
                ppou_pkg::MODE_INVERT:   w_pt[k] = ~r1_c[k];
                ppou_pkg::MODE_BRIGHTEN: w_pt[k] = w_bright[k];
                ppou_pkg::MODE_CONTRAST: w_pt[k] = w_contr[k];
                default:                 w_pt[k] = r1_c[k];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2) begin
            for (int k = 0; k < 4; k++) begin
                r2_c[k] <= r1_c[k];
            end
            for (int k = 0; k < 3; k++) begin
                r2_mask[k] <= w_mask[k];
                r2_pt[k]   <= w_pt[k];
            end
            r2_gray <= w_gray;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: mode / channel-count select into the output register
    // ---------------------------------------------------------------
    logic       w_color;
    logic [7:0] w_out [4];
    logic [7:0] r3_out [4];

    assign w_color = (r_chans >= ppou_pkg::COLOR_MIN_CHAN);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_out[k] = r2_c[k];
        end
        case (r_mode)
            ppou_pkg::MODE_AVG_GRAY,
            ppou_pkg::MODE_LUM_GRAY: begin
                if (w_color) begin
                    for (int k = 0; k < 3; k++) begin
                        w_out[k] = r2_gray;
                    end
                end
            end
            ppou_pkg::MODE_MASK: begin
                if (w_color) begin
                    for (int k = 0; k < 3; k++) begin
                        w_out[k] = r2_mask[k];
                    end
                end
            end
            ppou_pkg::MODE_INVERT,
            ppou_pkg::MODE_BRIGHTEN,
            ppou_pkg::MODE_CONTRAST: begin
                // gray pixels: only the first channel is processed
                w_out[0] = r2_pt[0];
                if (w_color) begin
                    w_out[1] = r2_pt[1];
                    w_out[2] = r2_pt[2];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy3) begin
            for (int k = 0; k < 4; k++) begin
                r3_out[k] <= w_out[k];
            end
        end
    end

    assign o_out_valid = r3_v;
    assign o_out0      = r3_out[0];
    assign o_out1      = r3_out[1];
    assign o_out2      = r3_out[2];
    assign o_out3      = r3_out[3];

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `PPOU_ASSERT_NOW(ast_busy_stalls, i_clk, i_rst_n, w_gain_st.busy, o_in_stall, "input taken during gain division")
    `PPOU_ASSERT_NEXT(ast_acc_fills_s1, i_clk, i_rst_n, w_in_acc, r1_v, "accepted word lost before stage one")
    `PPOU_ASSERT_NEXT(ast_adjust_starts_div, i_clk, i_rst_n, w_gain_start, w_gain_st.busy, "contrast write did not start the divider")
    `PPOU_ASSERT_NOW(ast_gain_range, i_clk, i_rst_n, w_gain_st.done, w_gain <= ppou_pkg::GAIN_MAX, "contrast gain out of range")

endmodule
